[hw/rtl/assert_macros.svh]
// Assertion macros used by the top-level RTL file of the matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define GNM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define GNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GNM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define GNM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/gnm_pkg.sv]
// Shared types and constants of the greedy nearest matcher.
`default_nettype none
package gnm_pkg;
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int TIME_BITS_DEF   = 10;
    localparam int SEQ_W    = 20;
    localparam int TS_W     = 10;
    localparam int CELL_W   = 12;
    localparam int CFG_W    = 16;
    localparam int ROWS_W   = 7;
    localparam int LIMIT_W  = 10;
    localparam int X_W      = 6;
    localparam int Y_W      = 12;
    localparam int DIV_STEPS = 12;
    localparam int MARGIN_W = 26;
    localparam int D2_W     = 25;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADLINE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd3;

    localparam logic [CFG_W-1:0]  SPEED_RST = 16'd256;
    localparam logic [ROWS_W-1:0] ROWS_RST  = 7'd30;
    localparam logic [ROWS_W-1:0] ROWS_MAX  = 7'd64;
    localparam logic [SEQ_W-1:0]  SEQ_MAX   = 20'hFFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic div_step;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

[hw/rtl/greedy_nearest_worker_request_matcher.sv]
// Greedy nearest worker/request matcher: one result beat per input beat.
// Input channel: i_in_valid / o_in_stall with is_request, time_slot and
//   cell_req; an item is taken when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall with matched, partner_seq,
//   dropped and match_total, held steady while stalled.
// Config: i_cfg_we writes register i_cfg_idx (0 deadline, 1 wait limit,
//   2 speed, 3 grid rows) with i_cfg_data; the user must write only while
//   the block is idle, and the block itself does not enforce it.
// Per item: an accept step, the divider steps for the cell split, the table
//   scan (one table entry per cycle through the single memory read port),
//   a pipeline drain and a commit. One item at a time.
// The result beat sits in an output register; the next item is accepted
//   while it waits, and that item's commit holds until the register frees.
// Reset (synchronous, active low) empties the table, clears the arrival and
//   match counters and loads the register defaults.
`default_nettype none
module greedy_nearest_worker_request_matcher #(
    parameter int TABLE_DEPTH = gnm_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = gnm_pkg::TIME_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [gnm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [gnm_pkg::CFG_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_is_request,
    input  wire logic [gnm_pkg::TS_W-1:0]       i_time_slot,
    input  wire logic [gnm_pkg::CELL_W-1:0]     i_cell_req,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_matched,
    output logic [gnm_pkg::SEQ_W-1:0]           o_partner_seq,
    output logic                                o_dropped,
    output logic [gnm_pkg::SEQ_W-1:0]           o_match_total
);
    import gnm_pkg::*;

    t_cmd                          cmd;
    t_sts                          sts;
    logic [$clog2(TABLE_DEPTH)-1:0] addr;

    gnm_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    gnm_dp #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_is_request  (i_is_request),
        .i_time_slot   (i_time_slot),
        .i_cell_req    (i_cell_req),
        .i_cmd         (cmd),
        .i_addr        (addr),
        .o_sts         (sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_matched     (o_matched),
        .o_partner_seq (o_partner_seq),
        .o_dropped     (o_dropped),
        .o_match_total (o_match_total)
    );

`include "assert_macros.svh"

    `GNM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input taken while a scan is pending")
    `GNM_ASSERT_IMPL(a_match_or_drop, i_clk, i_rst_n, o_out_valid, !(o_matched && o_dropped), "beat both matched and dropped")
    `GNM_ASSERT_IMPL(a_partner_zero, i_clk, i_rst_n, o_out_valid && !o_matched, o_partner_seq == '0, "partner set without a match")
    `GNM_ASSERT_IMPL(a_commit_room, i_clk, i_rst_n, cmd.commit, sts.out_free, "commit overwrites a waiting beat")
endmodule
`default_nettype wire

[hw/rtl/gnm_ctrl.sv]
// Sequencer: divide, scan the table, drain the pipe, commit the result.
`default_nettype none
module gnm_ctrl #(
    parameter int TABLE_DEPTH = gnm_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  gnm_pkg::t_sts                       i_sts,
    output gnm_pkg::t_cmd                       o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_addr
);
    import gnm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [3:0]    DIV_LAST  = 4'(DIV_STEPS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(TABLE_DEPTH - 1);

    t_state        r_state, n_state;
    logic [3:0]    r_div_cnt, n_div_cnt;
    logic [AW-1:0] r_addr, n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_cnt <= '0;
            r_addr    <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
            r_addr    <= n_addr;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        n_addr    = r_addr;
        case (r_state)
            S_IDLE: begin
                n_div_cnt = '0;
                if (i_in_valid) n_state = S_DIV;
            end
            S_DIV: begin
                n_div_cnt = r_div_cnt + 4'd1;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = S_SCAN;
                    n_addr  = '0;
                end
            end
            S_SCAN: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == ADDR_LAST) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall     = (r_state != S_IDLE);
        o_cmd.start    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.scan     = (r_state == S_SCAN);
        o_cmd.commit   = (r_state == S_DONE) && i_sts.out_free;
        o_addr         = r_addr;
    end
endmodule
`default_nettype wire

[hw/rtl/gnm_dp.sv]
// Datapath: config, cell divider, table memory, scan pipeline, result register.
`default_nettype none
module gnm_dp #(
    parameter int TABLE_DEPTH = gnm_pkg::TABLE_DEPTH_DEF,
    parameter int TIME_BITS   = gnm_pkg::TIME_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [gnm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [gnm_pkg::CFG_W-1:0]          i_cfg_data,
    input  wire logic                               i_is_request,
    input  wire logic [gnm_pkg::TS_W-1:0]           i_time_slot,
    input  wire logic [gnm_pkg::CELL_W-1:0]         i_cell_req,
    input  gnm_pkg::t_cmd                           i_cmd,
    input  wire logic [$clog2(TABLE_DEPTH)-1:0]     i_addr,
    output gnm_pkg::t_sts                           o_sts,
    input  wire logic                               i_out_stall,
    output logic                                    o_out_valid,
    output logic                                    o_matched,
    output logic [gnm_pkg::SEQ_W-1:0]               o_partner_seq,
    output logic                                    o_dropped,
    output logic [gnm_pkg::SEQ_W-1:0]               o_match_total
);
    import gnm_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int TB = TIME_BITS;
    localparam int CW = (TB > LIMIT_W) ? TB : LIMIT_W;

    // configuration
    logic [CFG_W-1:0]   r_deadline, r_speed;
    logic [LIMIT_W-1:0] r_wait_lim;
    logic [ROWS_W-1:0]  r_rows;
    logic [ROWS_W-1:0]  rows_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadline <= '0;
            r_wait_lim <= '0;
            r_speed    <= SPEED_RST;
            r_rows     <= ROWS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEADLINE: r_deadline <= i_cfg_data;
                CFG_WAIT_LIM: r_wait_lim <= i_cfg_data[LIMIT_W-1:0];
                CFG_SPEED:    r_speed    <= i_cfg_data;
                CFG_ROWS:     r_rows     <= i_cfg_data[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_rows == '0)          rows_eff = ROWS_W'(1);
        else if (r_rows > ROWS_MAX) rows_eff = ROWS_MAX;
        else                       rows_eff = r_rows;
    end

    // arriving item
    logic [TB-1:0] t_in;
    generate
        if (TB >= TS_W) begin : g_t_wide
            assign t_in = TB'(i_time_slot);
        end else begin : g_t_narrow
            assign t_in = i_time_slot[TB-1:0];
        end
    endgenerate

    logic              r_is_req;
    logic [TB-1:0]     r_t;
    logic [SEQ_W-1:0]  r_arrival;
    logic [SEQ_W-1:0]  r_match_cnt;

    // restoring divider: quotient shifts in over the cell bits
    logic [ROWS_W-1:0] r_rem;
    logic [CELL_W-1:0] r_quo;
    logic [ROWS_W-1:0] rem_sh;
    logic              q_bit;

    always_comb begin
        rem_sh = {r_rem[ROWS_W-2:0], r_quo[CELL_W-1]};
        q_bit  = (rem_sh >= rows_eff);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_is_req <= i_is_request;
            r_t      <= t_in;
            r_rem    <= '0;
            r_quo    <= i_cell_req;
        end else if (i_cmd.div_step) begin
            r_rem <= q_bit ? (rem_sh - rows_eff) : rem_sh;
            r_quo <= {r_quo[CELL_W-2:0], q_bit};
        end
    end

    logic [X_W-1:0] cur_x;
    logic [Y_W-1:0] cur_y;
    assign cur_x = r_rem[X_W-1:0];
    assign cur_y = r_quo;

    // table memory and valid bits
    logic              m_is_req [TABLE_DEPTH];
    logic [TB-1:0]     m_time   [TABLE_DEPTH];
    logic [X_W-1:0]    m_x      [TABLE_DEPTH];
    logic [Y_W-1:0]    m_y      [TABLE_DEPTH];
    logic [SEQ_W-1:0]  m_seq    [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_slot_valid;

    logic              r_best_found, r_free_found;
    logic [AW-1:0]     r_best_idx, r_free_idx;
    logic [D2_W-1:0]   r_best_d2;
    logic [SEQ_W-1:0]  r_best_seq;

    logic              rd_is_req;
    logic [TB-1:0]     rd_time;
    logic [X_W-1:0]    rd_x;
    logic [Y_W-1:0]    rd_y;
    logic [SEQ_W-1:0]  rd_seq;

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan) begin
            rd_is_req <= m_is_req[i_addr];
            rd_time   <= m_time[i_addr];
            rd_x      <= m_x[i_addr];
            rd_y      <= m_y[i_addr];
            rd_seq    <= m_seq[i_addr];
        end
        if (i_cmd.commit && !r_best_found && r_free_found) begin
            m_is_req[r_free_idx] <= r_is_req;
            m_time[r_free_idx]   <= r_t;
            m_x[r_free_idx]      <= cur_x;
            m_y[r_free_idx]      <= cur_y;
            m_seq[r_free_idx]    <= r_arrival;
        end
    end

    // pipeline stage 1: memory read beat
    logic          r_p1_v, r_p1_bit;
    logic [AW-1:0] r_p1_idx;

    // stage 1 combinational checks
    logic                  p1_cand;
    logic [TB-1:0]         t_diff;
    logic [MARGIN_W-1:0]   margin;
    logic                  t_late;
    logic signed [X_W:0]   dx;
    logic signed [Y_W:0]   dy;
    logic [CFG_W-1:0]      mg;

    always_comb begin
        t_late = (rd_time > r_t);
        t_diff = r_t - rd_time;
        margin = MARGIN_W'(r_deadline) - (MARGIN_W'(t_diff) << 8);
        p1_cand = r_p1_v && r_p1_bit && (rd_is_req != r_is_req);
        if (!r_is_req) begin
            if (t_late || margin[MARGIN_W-1]) p1_cand = 1'b0;
            mg = margin[CFG_W-1:0];
        end else begin
            if (!t_late && (CW'(t_diff) > CW'(r_wait_lim))) p1_cand = 1'b0;
            mg = r_deadline;
        end
        dx = $signed({1'b0, cur_x}) - $signed({1'b0, rd_x});
        dy = $signed({1'b0, cur_y}) - $signed({1'b0, rd_y});
    end

    // stage 2
    logic                 r_p2_v, r_p2_cand;
    logic signed [X_W:0]  r_p2_dx;
    logic signed [Y_W:0]  r_p2_dy;
    logic [CFG_W-1:0]     r_p2_mg;
    logic [SEQ_W-1:0]     r_p2_seq;
    logic [AW-1:0]        r_p2_idx;

    // stage 3
    logic                 r_p3_v, r_p3_cand;
    logic [11:0]          r_p3_dx2;
    logic [23:0]          r_p3_dy2;
    logic [31:0]          r_p3_reach;
    logic [SEQ_W-1:0]     r_p3_seq;
    logic [AW-1:0]        r_p3_idx;

    // stage 4
    logic                 r_p4_v, r_p4_cand;
    logic [D2_W-1:0]      r_p4_d2;
    logic [31:0]          r_p4_rrh;
    logic [SEQ_W-1:0]     r_p4_seq;
    logic [AW-1:0]        r_p4_idx;

    logic signed [2*X_W+1:0] dx2_full;
    logic signed [2*Y_W+1:0] dy2_full;
    logic [63:0]             rr_full;

    always_comb begin
        dx2_full = r_p2_dx * r_p2_dx;
        dy2_full = r_p2_dy * r_p2_dy;
        rr_full  = 64'(r_p3_reach) * 64'(r_p3_reach);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.scan;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_bit  <= r_slot_valid[i_addr];
        r_p1_idx  <= i_addr;

        r_p2_cand <= p1_cand;
        r_p2_dx   <= dx;
        r_p2_dy   <= dy;
        r_p2_mg   <= mg;
        r_p2_seq  <= rd_seq;
        r_p2_idx  <= r_p1_idx;

        r_p3_cand  <= r_p2_v && r_p2_cand;
        r_p3_dx2   <= dx2_full[11:0];
        r_p3_dy2   <= dy2_full[23:0];
        r_p3_reach <= 32'(r_p2_mg) * 32'(r_speed);
        r_p3_seq   <= r_p2_seq;
        r_p3_idx   <= r_p2_idx;

        r_p4_cand <= r_p3_v && r_p3_cand;
        r_p4_d2   <= D2_W'(r_p3_dx2) + D2_W'(r_p3_dy2);
        r_p4_rrh  <= rr_full[63:32];
        r_p4_seq  <= r_p3_seq;
        r_p4_idx  <= r_p3_idx;
    end

    // best candidate and first free entry
    logic p4_ok, p4_better;
    always_comb begin
        p4_ok = r_p4_v && r_p4_cand && (32'(r_p4_d2) <= r_p4_rrh);
        p4_better = !r_best_found || (r_p4_d2 < r_best_d2) ||
                    ((r_p4_d2 == r_best_d2) && (r_p4_seq < r_best_seq));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_best_found <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (p4_ok && p4_better) begin
                r_best_found <= 1'b1;
                r_best_d2    <= r_p4_d2;
                r_best_seq   <= r_p4_seq;
                r_best_idx   <= r_p4_idx;
            end
            if (r_p1_v && !r_p1_bit && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_p1_idx;
            end
        end
    end

    // commit: free the partner or store the arrival, load the result beat
    logic [SEQ_W-1:0] match_next;
    assign match_next = (r_best_found && r_match_cnt != SEQ_MAX) ?
                        r_match_cnt + SEQ_W'(1) : r_match_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_valid <= '0;
            r_arrival    <= '0;
            r_match_cnt  <= '0;
            o_out_valid  <= 1'b0;
        end else if (i_cmd.commit) begin
            if (r_best_found)      r_slot_valid[r_best_idx] <= 1'b0;
            else if (r_free_found) r_slot_valid[r_free_idx] <= 1'b1;
            r_arrival     <= r_arrival + SEQ_W'(1);
            r_match_cnt   <= match_next;
            o_out_valid   <= 1'b1;
            o_matched     <= r_best_found;
            o_partner_seq <= r_best_found ? r_best_seq : '0;
            o_dropped     <= !r_best_found && !r_free_found;
            o_match_total <= match_next;
        end else if (o_out_valid && !i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.pipe_busy = r_p1_v || r_p2_v || r_p3_v || r_p4_v;
        o_sts.out_free  = !o_out_valid || !i_out_stall;
    end
endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for the greedy nearest worker/request matcher: directed rows, then random phases.
`timescale 1ns / 1ps
module tb;
    import gnm_pkg::*;

    localparam int DEPTH = 256;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic             matched;
        logic [SEQ_W-1:0] partner;
        logic             dropped;
        logic [SEQ_W-1:0] total;
    } t_match_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  is_req;
        logic [TS_W-1:0]       ts;
        logic [CELL_W-1:0]     cell_idx;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        logic                  typed;
        t_match_res            res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_DEADLINE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic i_is_request = 1'b0;
    logic [TS_W-1:0] i_time_slot = '0;
    logic [CELL_W-1:0] i_cell_req = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic o_matched;
    logic [SEQ_W-1:0] o_partner_seq;
    logic o_dropped;
    logic [SEQ_W-1:0] o_match_total;

    greedy_nearest_worker_request_matcher i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_is_request(i_is_request), .i_time_slot(i_time_slot), .i_cell_req(i_cell_req),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_matched(o_matched), .o_partner_seq(o_partner_seq),
        .o_dropped(o_dropped), .o_match_total(o_match_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic             tbl_valid [DEPTH];
    logic             tbl_is_req [DEPTH];
    logic [TS_W-1:0]  tbl_ts [DEPTH];
    int unsigned      tbl_x [DEPTH];
    int unsigned      tbl_y [DEPTH];
    logic [SEQ_W-1:0] tbl_seq [DEPTH];
    logic [SEQ_W-1:0] arrivals = '0;
    logic [SEQ_W-1:0] match_cnt = '0;
    int unsigned deadline = 0, wait_lim = 0, speed = 256, rows_reg = 30;

    t_match_res pending_q[$];
    int errors = 0;
    int sent = 0;
    int cycles = 0;
    int snd_idle_pct = 29;
    int rcv_idle_pct = 71;
    int unsigned cur_ts = 0;
    int unsigned hot_cell = 0;

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    task automatic predict_match(input logic is_req, input logic [TS_W-1:0] ts,
                                 input logic [CELL_W-1:0] cell_idx, output t_match_res r);
        int unsigned rows, x, y;
        int best, free_idx;
        longint unsigned best_d2, d2, reach;
        longint margin, dx, dy, waited;
        logic [SEQ_W-1:0] best_seq;
        rows = (rows_reg == 0) ? 1 : (rows_reg > 64 ? 64 : rows_reg);
        x = cell_idx % rows;
        y = cell_idx / rows;
        best = -1;
        free_idx = -1;
        best_d2 = 0;
        best_seq = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_valid[i]) begin
                if (free_idx < 0) free_idx = i;
                continue;
            end
            if (tbl_is_req[i] == is_req) continue;
            dx = longint'(x) - longint'(tbl_x[i]);
            dy = longint'(y) - longint'(tbl_y[i]);
            d2 = dx * dx + dy * dy;
            if (!is_req) begin
                if (tbl_ts[i] > ts) continue;
                margin = longint'(deadline) - longint'(ts - tbl_ts[i]) * 256;
                if (margin < 0) continue;
                reach = longint'(margin) * speed;
            end else begin
                waited = longint'(ts) - longint'(tbl_ts[i]);
                if (waited > longint'(wait_lim)) continue;
                reach = longint'(deadline) * speed;
            end
            if ((d2 << 32) > reach * reach) continue;
            if (best < 0 || d2 < best_d2 || (d2 == best_d2 && tbl_seq[i] < best_seq)) begin
                best = i;
                best_d2 = d2;
                best_seq = tbl_seq[i];
            end
        end
        r = '0;
        if (best >= 0) begin
            tbl_valid[best] = 1'b0;
            r.matched = 1'b1;
            r.partner = best_seq;
            if (match_cnt != SEQ_MAX) match_cnt = match_cnt + 1'b1;
        end else if (free_idx >= 0) begin
            tbl_valid[free_idx] = 1'b1;
            tbl_is_req[free_idx] = is_req;
            tbl_ts[free_idx] = ts;
            tbl_x[free_idx] = x;
            tbl_y[free_idx] = y;
            tbl_seq[free_idx] = arrivals;
        end else begin
            r.dropped = 1'b1;
        end
        r.total = match_cnt;
        arrivals = arrivals + 1'b1;
    endtask

    // Drive one beat; keep valid high across back-to-back beats.
    task automatic send_item(input logic is_req, input logic [TS_W-1:0] ts,
                             input logic [CELL_W-1:0] cell_idx, input logic typed,
                             input t_match_res typed_res);
        t_match_res r;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < snd_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_is_request <= is_req;
        i_time_slot <= ts;
        i_cell_req <= cell_idx;
        do @(posedge i_clk); while (o_in_stall);
        predict_match(is_req, ts, cell_idx, r);
        pending_q = {pending_q, (typed ? typed_res : r)};
        sent++;
        if (sent == 383) begin
            snd_idle_pct = 71;
            rcv_idle_pct = 29;
        end else if (sent == 766) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
    endtask

    // Hold input until every result is back, then write the register.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DEADLINE: deadline = 32'(val);
            CFG_WAIT_LIM: wait_lim = 32'(val[LIMIT_W-1:0]);
            CFG_SPEED:    speed = 32'(val);
            CFG_ROWS:     rows_reg = 32'(val[ROWS_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int unsigned dl, input int unsigned wl, input int unsigned sp,
                             input int unsigned rw, input int count, input logic workers_only);
        logic is_req;
        int unsigned cell_idx;
        write_reg(CFG_DEADLINE, CFG_W'(dl));
        write_reg(CFG_WAIT_LIM, CFG_W'(wl));
        write_reg(CFG_SPEED, CFG_W'(sp));
        write_reg(CFG_ROWS, CFG_W'(rw));
        hot_cell = $urandom_range(0, 3900);
        for (int n = 0; n < count; n++) begin
            is_req = workers_only ? 1'b0 : 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 5)
                cur_ts = $urandom_range(0, 1023);
            else
                cur_ts = (cur_ts + $urandom_range(0, 1)) % 1024;
            if ($urandom_range(0, 99) < 70)
                cell_idx = hot_cell + $urandom_range(0, 190);
            else
                cell_idx = $urandom_range(0, 4095);
            send_item(is_req, cur_ts[TS_W-1:0], cell_idx[CELL_W-1:0], 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_match_res e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected beat, match_total", o_match_total, 0);
            end else begin
                e = pending_q.pop_front();
                if (o_matched !== e.matched) report_mismatch("matched", o_matched, e.matched);
                if (o_partner_seq !== e.partner)
                    report_mismatch("partner_seq", o_partner_seq, e.partner);
                if (o_dropped !== e.dropped) report_mismatch("dropped", o_dropped, e.dropped);
                if (o_match_total !== e.total)
                    report_mismatch("match_total", o_match_total, e.total);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    function automatic t_stim_row item_row(logic is_req, int unsigned ts, int unsigned cell_idx);
        t_stim_row row;
        row = '0;
        row.kind = ROW_ITEM;
        row.is_req = is_req;
        row.ts = TS_W'(ts);
        row.cell_idx = CELL_W'(cell_idx);
        return row;
    endfunction

    function automatic t_stim_row typed_row(logic is_req, int unsigned ts, int unsigned cell_idx,
                                            logic m, int unsigned p, logic d, int unsigned t);
        t_stim_row row;
        row = item_row(is_req, ts, cell_idx);
        row.typed = 1'b1;
        row.res = '{m, SEQ_W'(p), d, SEQ_W'(t)};
        return row;
    endfunction

    function automatic t_stim_row cfg_row(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        t_stim_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.reg_idx = idx;
        row.reg_val = CFG_W'(val);
        return row;
    endfunction

    initial begin
        t_stim_row dir_rows[$];
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        // register defaults: deadline 0, wait 0, speed 1.0, 30 rows
        dir_rows = {dir_rows, typed_row(1'b0, 0, 0, 1'b0, 0, 1'b0, 0)};
        dir_rows = {dir_rows, typed_row(1'b1, 0, 0, 1'b1, 0, 1'b0, 1)};
        dir_rows = {dir_rows, typed_row(1'b1, 0, 4095, 1'b0, 0, 1'b0, 1)};
        dir_rows = {dir_rows, typed_row(1'b0, 0, 4095, 1'b1, 2, 1'b0, 2)};
        // worker late, request earlier: negative wait passes
        dir_rows = {dir_rows, item_row(1'b0, 1023, 1)};
        dir_rows = {dir_rows, item_row(1'b1, 0, 1)};
        // tie on distance: lower sequence wins
        dir_rows = {dir_rows, cfg_row(CFG_DEADLINE, 16'h0400)};
        dir_rows = {dir_rows, item_row(1'b0, 5, 31)};
        dir_rows = {dir_rows, item_row(1'b0, 5, 91)};
        dir_rows = {dir_rows, item_row(1'b1, 5, 61)};
        // zero speed: only distance zero matches
        dir_rows = {dir_rows, cfg_row(CFG_SPEED, 0)};
        dir_rows = {dir_rows, item_row(1'b1, 6, 92)};
        dir_rows = {dir_rows, item_row(1'b1, 6, 91)};
        // worker arriving after a stored request at a later slot is skipped
        dir_rows = {dir_rows, item_row(1'b0, 4, 92)};
        // grid rows zero and above 64
        dir_rows = {dir_rows, cfg_row(CFG_ROWS, 0)};
        dir_rows = {dir_rows, item_row(1'b0, 7, 4095)};
        dir_rows = {dir_rows, cfg_row(CFG_ROWS, 127)};
        dir_rows = {dir_rows, cfg_row(CFG_SPEED, 16'hFFFF)};
        dir_rows = {dir_rows, cfg_row(CFG_WAIT_LIM, 1023)};
        dir_rows = {dir_rows, item_row(1'b1, 1023, 4095)};
        dir_rows = {dir_rows, item_row(1'b1, 1023, 2730)};
        dir_rows = {dir_rows, item_row(1'b0, 1023, 1365)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG)
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            else
                send_item(dir_rows[k].is_req, dir_rows[k].ts, dir_rows[k].cell_idx,
                          dir_rows[k].typed, dir_rows[k].res);
        end

        cur_ts = 10;
        // fill the table with workers until beats get dropped
        run_phase(0, 0, 256, 30, 300, 1'b1);
        run_phase(16'hFFFF, 1023, 16'hFFFF, 64, 150, 1'b0);
        run_phase(16'h0200, 3, 16'h0100, 1, 150, 1'b0);
        run_phase(16'h0800, 10, 16'h0080, 0, 150, 1'b0);
        run_phase(16'h0300, 2, 0, 127, 100, 1'b0);
        repeat (4) begin
            run_phase($urandom_range(0, 16'h0C00), $urandom_range(0, 20),
                      $urandom_range(0, 16'h0400), $urandom_range(1, 64), 75, 1'b0);
        end

        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/gnm_pkg.sv
hw/rtl/gnm_ctrl.sv
hw/rtl/gnm_dp.sv
hw/rtl/greedy_nearest_worker_request_matcher.sv
tb/sv/tb.sv
